// ----- rtl/core/mfc_pkg.sv -----
package mfc_pkg;

  localparam int RuleDepthDef  = 16;
  localparam int GateCountDef  = 8;
  localparam int WordsPerRule  = 6;
  localparam int Ipv4Bits      = 32;
  localparam int Ipv6Bits      = 128;
  localparam int QueueDepth    = 2;

  localparam logic       CMD_CLASSIFY = 1'b0;
  localparam logic       CMD_WRITE    = 1'b1;
  localparam logic [1:0] NET_IPV4     = 2'd1;
  localparam logic [1:0] NET_IPV6     = 2'd2;

  typedef struct packed {
    logic [2:0]  flags;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  proto;
    logic [7:0]  tclass;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_t;

  // front -> back: oldest waiting classify request
  typedef struct packed {
    logic valid;
    hdr_t hdr;
  } hq_head_t;

  // back -> front
  typedef struct packed {
    logic busy;
    logic pop;
  } bk_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } bk_state_t;

  // address / 6 for a 7-bit word address: (a * 43) >> 8 is exact below 128
  function automatic logic [4:0] rule_of(input logic [6:0] a);
    logic [12:0] prod;
    prod = 13'(a) * 13'd43;
    return prod[12:8];
  endfunction

  function automatic logic [2:0] word_of(input logic [6:0] a);
    logic [6:0] base;
    base = 7'(rule_of(a)) * 7'd6;
    return 3'(a - base);
  endfunction

endpackage

// ----- rtl/core/mfc_ram.sv -----
module mfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/core/mfc_front.sv -----
module mfc_front import mfc_pkg::*; #(
  parameter int RULE_DEPTH = RuleDepthDef,
  localparam int RIDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_command,
  input  logic [6:0]        in_rule_word_address,
  input  logic [63:0]       in_rule_word_data,
  input  hdr_t              in_hdr,
  output logic              wr_en,
  output logic [2:0]        wr_word,
  output logic [RIDX_W-1:0] wr_rule,
  output logic [63:0]       wr_data,
  output hq_head_t          head,
  input  bk_stat_t          bk_stat
);

  localparam int AddrLimit = RULE_DEPTH * WordsPerRule;

  hdr_t       hq_r [QueueDepth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       hq_full, accept, push_hq;
  logic [31:0] rule_wide;

  assign hq_full = (cnt_r == 2'(QueueDepth));
  // a write waits until every earlier classify has finished
  assign in_full = (in_command == CMD_WRITE) ? ((cnt_r != 2'd0) || bk_stat.busy) : hq_full;
  assign accept  = in_push && !in_full;
  assign push_hq = accept && (in_command == CMD_CLASSIFY);

  assign rule_wide = 32'(rule_of(in_rule_word_address));
  assign wr_en   = accept && (in_command == CMD_WRITE) &&
                   (32'(in_rule_word_address) < AddrLimit);
  assign wr_word = word_of(in_rule_word_address);
  assign wr_rule = rule_wide[RIDX_W-1:0];
  assign wr_data = in_rule_word_data;

  assign head.valid = (cnt_r != 2'd0);
  assign head.hdr   = hq_r[rp_r];

  always_comb begin
    wp_nxt  = push_hq ? ~wp_r : wp_r;
    rp_nxt  = bk_stat.pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_hq) - 2'(bk_stat.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_hq) begin
      hq_r[wp_r] <= in_hdr;
    end
  end

endmodule

// ----- rtl/core/mfc_back.sv -----
module mfc_back import mfc_pkg::*; #(
  parameter int RULE_DEPTH = RuleDepthDef,
  parameter int GATE_COUNT = GateCountDef,
  localparam int RIDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1,
  localparam int CNT_W  = $clog2(RULE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [4:0]        rule_count,
  input  hq_head_t          head,
  output bk_stat_t          bk_stat,
  output logic              rd_en,
  output logic [RIDX_W-1:0] rd_rule,
  input  logic [63:0]       rd_w0,
  input  logic [63:0]       rd_w1,
  input  logic [63:0]       rd_w2,
  input  logic [63:0]       rd_w3,
  input  logic [63:0]       rd_w4,
  input  logic [63:0]       rd_w5,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_matched,
  output logic [2:0]        out_gate
);

  function automatic logic pfx_ok(input logic [1:0] net, input logic [63:0] ph,
                                  input logic [63:0] pl, input logic [63:0] rh,
                                  input logic [63:0] rl, input logic [7:0] plen);
    logic [5:0]   p4;
    logic [7:0]   p6;
    logic [31:0]  m4;
    logic [127:0] m6;
    p4 = (plen > 8'(Ipv4Bits)) ? 6'(Ipv4Bits) : plen[5:0];
    p6 = (plen > 8'(Ipv6Bits)) ? 8'(Ipv6Bits) : plen;
    m4 = ~({32{1'b1}} >> p4);
    m6 = ~({128{1'b1}} >> p6);
    if (net == NET_IPV4) begin
      return ((pl[31:0] ^ rl[31:0]) & m4) == 32'd0;
    end
    return (({ph, pl} ^ {rh, rl}) & m6) == 128'd0;
  endfunction

  function automatic logic rule_hit(input hdr_t h, input logic [63:0] w0,
                                    input logic [63:0] w1, input logic [63:0] w2,
                                    input logic [63:0] w3, input logic [63:0] w4,
                                    input logic [63:0] w5);
    logic [1:0] net;
    logic       ok, smin_v, dmin_v;
    logic [7:0] tmask;
    net   = h.flags[1:0];
    ok    = (net == NET_IPV4) || (net == NET_IPV6);
    if (32'(w4[60:53]) >= GATE_COUNT) ok = 1'b0;
    if (w4[9:2] != 8'd0 &&
        (w4[1:0] != net || !pfx_ok(net, h.src_hi, h.src_lo, w0, w1, w4[9:2])))
      ok = 1'b0;
    if (w4[19:12] != 8'd0 &&
        (w4[11:10] != net || !pfx_ok(net, h.dst_hi, h.dst_lo, w2, w3, w4[19:12])))
      ok = 1'b0;
    if (w4[20] && w4[28:21] != h.proto) ok = 1'b0;
    if (w4[29] && w4[35:30] != h.tclass[7:2]) ok = 1'b0;
    tmask = w4[52:45];
    if (w4[36] && tmask != 8'd0 && (w4[44:37] & tmask) != (h.tclass & tmask)) ok = 1'b0;
    smin_v = w4[61];
    dmin_v = w4[62];
    if (smin_v || dmin_v) begin
      if (!h.flags[2]) ok = 1'b0;
      if (smin_v && h.sport < w5[15:0]) ok = 1'b0;
      if (h.sport > w5[31:16]) ok = 1'b0;
      if (dmin_v && h.dport < w5[47:32]) ok = 1'b0;
      if (h.dport > w5[63:48]) ok = 1'b0;
    end
    return ok;
  endfunction

  bk_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt, eidx_r, n_eff;
  logic           vld_r, hit, done, start, res_push, res_match;
  logic [2:0]     res_gate;

  logic [3:0] oq_r [QueueDepth];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       oq_full;

  assign n_eff = (32'(rule_count) > RULE_DEPTH) ? CNT_W'(RULE_DEPTH) : CNT_W'(rule_count);
  assign oq_full = (ocnt_r == 2'(QueueDepth));

  assign hit  = rule_hit(head.hdr, rd_w0, rd_w1, rd_w2, rd_w3, rd_w4, rd_w5);
  assign done = vld_r && (hit || eidx_r == CNT_W'(n_eff - 1'b1));
  // one search at a time and only with room for its result
  assign start = (state_r == ST_IDLE) && head.valid && !oq_full;

  assign rd_en   = (state_r == ST_SEARCH) && (rd_idx_r < n_eff) && !done;
  assign rd_rule = rd_idx_r[RIDX_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_idx_nxt = '0;
        if (start && n_eff != '0) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (rd_en) rd_idx_nxt = rd_idx_r + 1'b1;
        if (done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_push  = 1'b0;
    res_match = 1'b0;
    res_gate  = 3'd0;
    unique case (state_r)
      ST_IDLE: res_push = start && (n_eff == '0);
      ST_SEARCH: begin
        res_push  = done;
        res_match = hit;
        res_gate  = hit ? rd_w4[55:53] : 3'd0;
      end
      default: res_push = 1'b0;
    endcase
  end

  assign bk_stat.busy = (state_r != ST_IDLE);
  assign bk_stat.pop  = res_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
      vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      vld_r    <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) eidx_r <= rd_idx_r;
  end

  // result queue
  logic out_take;
  assign out_empty   = (ocnt_r == 2'd0);
  assign out_take    = out_pop && !out_empty;
  assign out_matched = oq_r[orp_r][3];
  assign out_gate    = oq_r[orp_r][2:0];
  assign ocnt_nxt    = ocnt_r + 2'(res_push) - 2'(out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (res_push) owp_r <= ~owp_r;
      if (out_take) orp_r <= ~orp_r;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) oq_r[owp_r] <= {res_match, res_gate};
  end

endmodule

// ----- rtl/core/multi_field_first_match_classifier.sv -----
// Multi-field first-match packet classifier. Push one request per cycle while
// full is low: a write request stores one 64-bit rule word (address is rule*6
// plus word, beyond the table it is dropped), a classify request carries the
// packet's header fields and yields exactly one result (matched, out_gate).
// Rules 0..rule_count-1 are tried in order, one rule per cycle from six rule
// RAMs (one per word, registered read), and one search runs at a time. A short
// request queue sits in front of the search and a two-entry result queue
// behind it. A write is held off (full high) until all earlier classifies are
// done. Rule words read before being written are undefined. rule_count is
// written through cfg_we/cfg_data; the user must write it only while idle, as
// nothing in the block enforces this. Above RULE_DEPTH it saturates. A rule
// with gate not below GATE_COUNT never matches.
module multi_field_first_match_classifier import mfc_pkg::*; #(
  parameter int RULE_DEPTH = RuleDepthDef,
  parameter int GATE_COUNT = GateCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_command,
  input  logic [6:0]  in_rule_word_address,
  input  logic [63:0] in_rule_word_data,
  input  logic [2:0]  in_header_flags,
  input  logic [63:0] in_source_address_high,
  input  logic [63:0] in_source_address_low,
  input  logic [63:0] in_dest_address_high,
  input  logic [63:0] in_dest_address_low,
  input  logic [7:0]  in_protocol_number,
  input  logic [7:0]  in_traffic_class,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_matched,
  output logic [2:0]  out_gate
);

  localparam int RIDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

  logic [4:0] rule_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= 5'd0;
    end else if (cfg_we) begin
      rule_count_r <= cfg_data;
    end
  end

  hdr_t              in_hdr;
  hq_head_t          head;
  bk_stat_t          bk_stat;
  logic              wr_en, rd_en;
  logic [2:0]        wr_word;
  logic [RIDX_W-1:0] wr_rule, rd_rule;
  logic [63:0]       wr_data;
  logic [63:0]       rd_w [WordsPerRule];

  assign in_hdr = '{flags: in_header_flags, src_hi: in_source_address_high,
                    src_lo: in_source_address_low, dst_hi: in_dest_address_high,
                    dst_lo: in_dest_address_low, proto: in_protocol_number,
                    tclass: in_traffic_class, sport: in_source_port,
                    dport: in_dest_port};

  mfc_front #(.RULE_DEPTH(RULE_DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_command, .in_rule_word_address,
    .in_rule_word_data, .in_hdr, .wr_en, .wr_word, .wr_rule, .wr_data,
    .head, .bk_stat
  );

  // one RAM per rule word, all read at the same rule whenever rd_en is high
  for (genvar g = 0; g < WordsPerRule; g++) begin : g_word
    mfc_ram #(.WIDTH(64), .DEPTH(RULE_DEPTH)) u_ram (
      .clk,
      .we     (wr_en && (wr_word == 3'(g))),
      .waddr  (wr_rule),
      .wdata  (wr_data),
      .re     (rd_en),
      .raddr  (rd_rule),
      .rdata_r(rd_w[g])
    );
  end

  mfc_back #(.RULE_DEPTH(RULE_DEPTH), .GATE_COUNT(GATE_COUNT)) u_back (
    .clk, .rst_n, .rule_count(rule_count_r), .head, .bk_stat, .rd_en, .rd_rule,
    .rd_w0(rd_w[0]), .rd_w1(rd_w[1]), .rd_w2(rd_w[2]), .rd_w3(rd_w[3]),
    .rd_w4(rd_w[4]), .rd_w5(rd_w[5]), .out_empty, .out_pop, .out_matched, .out_gate
  );

endmodule

// ----- tb/mfc_classifier_checker.sv -----
module mfc_classifier_checker import mfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_command,
  input  logic [6:0]  in_rule_word_address,
  input  logic [63:0] in_rule_word_data,
  input  logic [2:0]  in_header_flags,
  input  logic [63:0] in_source_address_high,
  input  logic [63:0] in_source_address_low,
  input  logic [63:0] in_dest_address_high,
  input  logic [63:0] in_dest_address_low,
  input  logic [7:0]  in_protocol_number,
  input  logic [7:0]  in_traffic_class,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_matched,
  input  logic [2:0]  out_gate,
  output int          errors,
  output int          pending,
  output int          results,
  output int          hits
);

  typedef struct packed {
    logic       matched;
    logic [2:0] gate;
  } verdict_t;

  logic [63:0] rules [RuleDepthDef*WordsPerRule];
  logic [4:0]  rule_count;
  verdict_t    verdicts_due[$];

  function automatic logic prefix_ok(logic [1:0] net, logic [63:0] ph, logic [63:0] pl,
                                     logic [63:0] rh, logic [63:0] rl, logic [7:0] plen);
    logic [127:0] m6;
    logic [31:0]  m4;
    int           n;
    if (net == NET_IPV4) begin
      n  = (plen > Ipv4Bits) ? Ipv4Bits : plen;
      m4 = (n == 0) ? '0 : (32'hFFFF_FFFF << (Ipv4Bits - n));
      return ((pl[31:0] ^ rl[31:0]) & m4) == '0;
    end
    n  = (plen > Ipv6Bits) ? Ipv6Bits : plen;
    m6 = (n == 0) ? '0 : ({128{1'b1}} << (Ipv6Bits - n));
    return (({ph, pl} ^ {rh, rl}) & m6) == '0;
  endfunction

  function automatic logic rule_fits(int k, hdr_t h);
    logic [63:0] w4;
    logic [63:0] w5;
    logic [1:0]  net;
    logic [7:0]  tmask;
    w4  = rules[k*WordsPerRule+4];
    w5  = rules[k*WordsPerRule+5];
    net = h.flags[1:0];
    tmask = w4[52:45];
    if (net != NET_IPV4 && net != NET_IPV6) return 1'b0;
    if (w4[60:53] >= GateCountDef) return 1'b0;
    if (w4[9:2] != 0 && (w4[1:0] != net || !prefix_ok(net, h.src_hi, h.src_lo,
        rules[k*WordsPerRule], rules[k*WordsPerRule+1], w4[9:2]))) return 1'b0;
    if (w4[19:12] != 0 && (w4[11:10] != net || !prefix_ok(net, h.dst_hi, h.dst_lo,
        rules[k*WordsPerRule+2], rules[k*WordsPerRule+3], w4[19:12]))) return 1'b0;
    if (w4[20] && w4[28:21] != h.proto) return 1'b0;
    if (w4[29] && w4[35:30] != h.tclass[7:2]) return 1'b0;
    if (w4[36] && tmask != 0 && (w4[44:37] & tmask) != (h.tclass & tmask)) return 1'b0;
    if (!w4[61] && !w4[62]) return 1'b1;
    if (!h.flags[2]) return 1'b0;
    if (w4[61] && h.sport < w5[15:0]) return 1'b0;
    if (h.sport > w5[31:16]) return 1'b0;
    if (w4[62] && h.dport < w5[47:32]) return 1'b0;
    if (h.dport > w5[63:48]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic verdict_t predict_gate(hdr_t h);
    verdict_t v;
    int       n;
    v = '0;
    n = (rule_count > RuleDepthDef) ? RuleDepthDef : rule_count;
    for (int k = 0; k < n; k++) begin
      if (rule_fits(k, h)) begin
        v.matched = 1'b1;
        v.gate    = rules[k*WordsPerRule+4][55:53];
        return v;
      end
    end
    return v;
  endfunction

  assign pending = verdicts_due.size();

  always @(posedge clk) begin
    hdr_t     h;
    verdict_t v;
    if (!rst_n) begin
      rule_count = '0;
      verdicts_due.delete();
    end else begin
      if (cfg_we) rule_count = cfg_data;
      if (in_push && !in_full) begin
        if (in_command == CMD_WRITE) begin
          if (in_rule_word_address < RuleDepthDef*WordsPerRule)
            rules[in_rule_word_address] = in_rule_word_data;
        end else begin
          h = '{in_header_flags, in_source_address_high, in_source_address_low,
                in_dest_address_high, in_dest_address_low, in_protocol_number,
                in_traffic_class, in_source_port, in_dest_port};
          verdicts_due.insert(verdicts_due.size(), predict_gate(h));
        end
      end
      if (out_pop && !out_empty) begin
        results++;
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result matched=%0d gate=%0d",
                                     out_matched, out_gate);
        end else begin
          v = verdicts_due.pop_front();
          if (v.matched) hits++;
          if (v.matched !== out_matched || v.gate !== out_gate) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected matched=%0d gate=%0d, got matched=%0d gate=%0d",
                       results, v.matched, v.gate, out_matched, out_gate);
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_multi_field_first_match_classifier.sv -----
module tb_multi_field_first_match_classifier;
  import mfc_pkg::*;

  // one request as the sender sees it
  typedef struct {
    logic        cmd;
    logic [6:0]  addr;
    logic [63:0] data;
    hdr_t        hdr;
  } req_t;

  localparam int Words      = RuleDepthDef*WordsPerRule;
  localparam int CycleLimit = 600000;
  localparam int DrainWait  = 30;   // search of RULE_DEPTH rules plus queues

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_command = CMD_CLASSIFY;
  logic [6:0]  in_rule_word_address = '0;
  logic [63:0] in_rule_word_data = '0;
  logic [2:0]  in_header_flags = '0;
  logic [63:0] in_source_address_high = '0;
  logic [63:0] in_source_address_low = '0;
  logic [63:0] in_dest_address_high = '0;
  logic [63:0] in_dest_address_low = '0;
  logic [7:0]  in_protocol_number = '0;
  logic [7:0]  in_traffic_class = '0;
  logic [15:0] in_source_port = '0;
  logic [15:0] in_dest_port = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_matched;
  logic [2:0]  out_gate;

  int errors, pending, results, hits;
  int send_idle = 0, recv_idle = 0;   // percent of cycles each side idles
  int cycles = 0;
  int sent = 0;

  // stimulus-side copy of the rule table, only to aim packets at rules
  logic [63:0] shadow [Words];

  always #5 clk = ~clk;

  multi_field_first_match_classifier u_dut (
    .clk, .rst_n, .cfg_we, .cfg_data, .in_push, .in_full, .in_command,
    .in_rule_word_address, .in_rule_word_data, .in_header_flags,
    .in_source_address_high, .in_source_address_low, .in_dest_address_high,
    .in_dest_address_low, .in_protocol_number, .in_traffic_class,
    .in_source_port, .in_dest_port, .out_empty, .out_pop, .out_matched, .out_gate
  );

  mfc_classifier_checker u_chk (
    .clk, .rst_n, .cfg_we, .cfg_data, .in_push, .in_full, .in_command,
    .in_rule_word_address, .in_rule_word_data, .in_header_flags,
    .in_source_address_high, .in_source_address_low, .in_dest_address_high,
    .in_dest_address_low, .in_protocol_number, .in_traffic_class,
    .in_source_port, .in_dest_port, .out_empty, .out_pop, .out_matched, .out_gate,
    .errors, .pending, .results, .hits
  );

  // receiver: pop decided each falling edge
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Entered and left at a falling edge with push held; a following idle or
  // request is then the only assignment to push in that step.
  task automatic send(req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push                <= 1'b1;
    in_command             <= r.cmd;
    in_rule_word_address   <= r.addr;
    in_rule_word_data      <= r.data;
    in_header_flags        <= r.hdr.flags;
    in_source_address_high <= r.hdr.src_hi;
    in_source_address_low  <= r.hdr.src_lo;
    in_dest_address_high   <= r.hdr.dst_hi;
    in_dest_address_low    <= r.hdr.dst_lo;
    in_protocol_number     <= r.hdr.proto;
    in_traffic_class       <= r.hdr.tclass;
    in_source_port         <= r.hdr.sport;
    in_dest_port           <= r.hdr.dport;
    do @(posedge clk); while (in_full);
    if (r.cmd == CMD_WRITE && r.addr < Words) shadow[r.addr] = r.data;
    sent++;
    @(negedge clk);
  endtask

  task automatic write_word(int a, logic [63:0] d);
    req_t r;
    r = '{CMD_WRITE, 7'(a), d, hdr_t'($urandom)};
    send(r);
  endtask

  task automatic classify(hdr_t h);
    req_t r;
    r = '{CMD_CLASSIFY, 7'($urandom), {$urandom, $urandom}, h};
    send(r);
  endtask

  // hold the sender until every result is back and the search has gone quiet
  task automatic drain();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic set_rule_count(logic [4:0] n);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [63:0] rule_w4(logic [1:0] st, logic [7:0] sl, logic [1:0] dt,
      logic [7:0] dl, logic pv, logic [7:0] p, logic dv, logic [5:0] ds, logic tv,
      logic [7:0] tos, logic [7:0] tm, logic [7:0] g, logic smv, logic dmv);
    return {1'b0, dmv, smv, g, tm, tos, tv, ds, dv, p, pv, dl, dt, sl, st};
  endfunction

  function automatic logic [7:0] rand_plen();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'($urandom_range(255));
      2:       return 8'd32;
      3:       return 8'd128;
      default: return 8'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] rand_max();
    return $urandom_range(2) == 0 ? 16'hFFFF : 16'($urandom);
  endfunction

  task automatic write_rand_rule(int k);
    logic [1:0] t;
    t = $urandom_range(7) == 0 ? 2'($urandom) : ($urandom_range(1) ? NET_IPV4 : NET_IPV6);
    for (int w = 0; w < 4; w++) write_word(k*WordsPerRule + w, {$urandom, $urandom});
    write_word(k*WordsPerRule + 4,
      rule_w4(t, rand_plen(), t, rand_plen(), $urandom_range(3) == 0, 8'($urandom),
              $urandom_range(3) == 0, 6'($urandom), $urandom_range(1), 8'($urandom),
              $urandom_range(2) == 0 ? 8'd0 : 8'($urandom),
              $urandom_range(5) == 0 ? 8'($urandom) : 8'($urandom_range(7)),
              $urandom_range(1), $urandom_range(1)));
    write_word(k*WordsPerRule + 5, {rand_max(), 16'($urandom_range(2000)),
                                    rand_max(), 16'($urandom_range(2000))});
  endtask

  function automatic hdr_t noise_hdr();
    logic [319:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    return rnd[$bits(hdr_t)-1:0];
  endfunction

  // a packet built to pass most checks of rule k, with random disturbance
  function automatic hdr_t aimed_hdr(int k);
    hdr_t        h;
    logic [63:0] w4, w5;
    w4 = shadow[k*WordsPerRule+4];
    w5 = shadow[k*WordsPerRule+5];
    h  = noise_hdr();
    h.flags  = {$urandom_range(7) != 0, $urandom_range(9) == 0 ? 2'($urandom) : w4[1:0]};
    h.src_hi = shadow[k*WordsPerRule];
    h.src_lo = shadow[k*WordsPerRule+1] ^ (64'($urandom_range(3)) << $urandom_range(63));
    h.dst_hi = shadow[k*WordsPerRule+2];
    h.dst_lo = shadow[k*WordsPerRule+3] ^ (64'($urandom_range(1)) << $urandom_range(63));
    if ($urandom_range(4) != 0) h.proto = w4[28:21];
    if ($urandom_range(4) != 0) h.tclass = {w4[35:30], 2'($urandom)};
    if ($urandom_range(3) != 0) begin
      h.sport = w5[15:0] + 16'($urandom_range(3));
      h.dport = w5[63:48] - 16'($urandom_range(3));
    end
    return h;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(3) == 0) write_word($urandom_range(127), {$urandom, $urandom});
        else write_rand_rule($urandom_range(RuleDepthDef-1));
      end else if ($urandom_range(99) < 75) begin
        classify(aimed_hdr($urandom_range(RuleDepthDef-1)));
      end else begin
        classify(noise_hdr());
      end
      if (i == n/2 && send_idle != 0) drain();   // sender waits for an empty pipe
    end
  endtask

  initial begin
    hdr_t h;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: rule 0 bad gate, 1 IPv4 src over-long prefix, 2 IPv6 /128
    // dst, 3 port window, 4 protocol with zero tos mask, 5 DSCP, 6 invalid
    // address type, 7 catch-all; the rest random
    for (int k = 0; k < RuleDepthDef; k++) write_rand_rule(k);
    write_word(0*6+4, rule_w4(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd9, 0, 0));
    write_word(1*6+1, 64'h0000_0000_C0A8_0001);
    write_word(1*6+4, rule_w4(NET_IPV4, 8'd200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd1, 0, 0));
    write_word(2*6+2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_word(2*6+3, 64'h0123_4567_89AB_CDEF);
    write_word(2*6+4, rule_w4(0, 0, NET_IPV6, 8'd128, 0, 0, 0, 0, 0, 0, 0, 8'd2, 0, 0));
    write_word(3*6+4, rule_w4(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd3, 1, 0));
    write_word(3*6+5, {16'hFFFF, 16'd0, 16'd200, 16'd100});
    write_word(4*6+4, rule_w4(0, 0, 0, 0, 1, 8'd17, 0, 0, 1, 8'hAB, 0, 8'd4, 0, 0));
    write_word(5*6+4, rule_w4(0, 0, 0, 0, 0, 0, 1, 6'd46, 0, 0, 0, 8'd5, 0, 0));
    write_word(6*6+4, rule_w4(2'd3, 8'd8, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd6, 0, 0));
    write_word(7*6+4, rule_w4(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd7, 0, 0));
    write_word(96, '1);    // beyond the table: dropped
    write_word(127, '0);
    set_rule_count(5'd16);

    h = '0;                            classify(h);  // network type none
    h.flags = 3'b111;                  classify(h);  // type 3 counts as none
    h = '1;                            classify(h);  // all ones, still none
    h = '0; h.flags = {1'b0, NET_IPV4}; h.src_lo = 64'hFFFF_FFFF_C0A8_0001;
    classify(h);                                     // IPv4 /32 hit, upper bits ignored
    h.src_lo = 64'h0000_0000_C0A8_0002; h.proto = 8'd17;
    classify(h);                                     // protocol, zero tos mask
    h = '0; h.flags = {1'b1, NET_IPV6}; h.dst_hi = '1; h.dst_lo = 64'h0123_4567_89AB_CDEF;
    classify(h);                                     // IPv6 /128 hit
    h.dst_lo[0] = 1'b1; h.sport = 16'd100;  classify(h);  // port at minimum
    h.sport = 16'd200;                      classify(h);  // port at maximum
    h.sport = 16'd201;                      classify(h);  // just above
    h.flags[2] = 1'b0; h.sport = 16'd150;   classify(h);  // no transport header
    h.tclass = {6'd46, 2'b11};              classify(h);  // DSCP
    h = '1; h.flags = {1'b1, NET_IPV4};     classify(h);
    h.flags = {1'b0, NET_IPV6}; h.sport = '0; h.dport = '0; classify(h);

    set_rule_count(5'd0);              // nothing searched
    classify(aimed_hdr(7));
    classify(noise_hdr());
    set_rule_count(5'd31);             // saturates to the table depth
    classify(aimed_hdr(3));

    send_idle = 37; recv_idle = 46;
    set_rule_count(5'd16);
    random_phase(200);
    send_idle = 46; recv_idle = 37;
    set_rule_count(5'd31);
    random_phase(200);
    send_idle = 0; recv_idle = 0;
    set_rule_count(5'($urandom_range(1, 15)));
    random_phase(100);
    set_rule_count(5'd1);
    random_phase(100);

    drain();
    $display("%0d requests sent, %0d results checked, %0d of them matched a rule",
             sent, results, hits);
    $display("rule counts 0, 1, 16 and 31 with mixed idling on both channels");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mfc_pkg.sv
rtl/core/mfc_ram.sv
rtl/core/mfc_front.sv
rtl/core/mfc_back.sv
rtl/core/multi_field_first_match_classifier.sv
tb/mfc_classifier_checker.sv
tb/tb_multi_field_first_match_classifier.sv
